// ===== hdl/spi_to_bus_bridge_slave_unit_defines.svh =====
// Assertion macros for the bridge checker.
`ifndef SPI_TO_BUS_BRIDGE_SLAVE_UNIT_DEFINES_SVH
`define SPI_TO_BUS_BRIDGE_SLAVE_UNIT_DEFINES_SVH

// Concurrent assertion, masked while reset is low.
`define SBB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion, also checked during reset.
`define SBB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sbb_pkg.sv =====
// Types and constants for the SPI-to-bus bridge slave.
package sbb_pkg;

    // Bus address width of the burst counter
    localparam int ADDR_BITS = 24;

    // Command bytes
    localparam logic [7:0] CMD_READ   = 8'ha4;
    localparam logic [7:0] CMD_WRITE  = 8'hac;
    localparam logic [7:0] CMD_CFG_RD = 8'hb0;
    localparam logic [7:0] CMD_CFG_WR = 8'hb8;
    localparam logic [7:0] CMD_STATUS = 8'hb2;

    // APB register map
    localparam int         APB_ADDR_W    = 3;
    localparam logic [APB_ADDR_W-1:0] REG_ADDR_STEP = 3'd0;
    localparam logic [7:0] STEP_RESET    = 8'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR,
        PH_DUMMY,
        PH_RDATA,
        PH_WDATA,
        PH_REPLY,
        PH_CFGWR,
        PH_DRAIN
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_READ,
        KIND_WRITE,
        KIND_BAD
    } t_kind;

    // One received SPI exchange
    typedef struct packed {
        logic        frame_end;
        logic [7:0]  mosi_byte;
        logic [31:0] read_word;
        logic [23:0] status_word;
    } t_in_word;

    // One result word
    typedef struct packed {
        logic [7:0]  miso_byte;
        logic        bus_read;
        logic        bus_write;
        logic [23:0] bus_address;
        logic [31:0] write_word;
        logic [23:0] config_value;
        logic        frame_error;
    } t_out_word;

endpackage

// ===== hdl/sbb_if.sv =====
// Valid/ready channel interfaces for the bridge input and result words.
interface sbb_in_if;
    import sbb_pkg::*;

    logic        valid;
    logic        ready;
    logic        frame_end;
    logic [7:0]  mosi_byte;
    logic [31:0] read_word;
    logic [23:0] status_word;

    modport source (output valid, frame_end, mosi_byte, read_word, status_word, input ready);
    modport sink   (input valid, frame_end, mosi_byte, read_word, status_word, output ready);
endinterface

interface sbb_out_if;
    import sbb_pkg::*;

    logic        valid;
    logic        ready;
    logic [7:0]  miso_byte;
    logic        bus_read;
    logic        bus_write;
    logic [23:0] bus_address;
    logic [31:0] write_word;
    logic [23:0] config_value;
    logic        frame_error;

    modport source (output valid, miso_byte, bus_read, bus_write, bus_address, write_word,
                     config_value, frame_error, input ready);
    modport sink   (input valid, miso_byte, bus_read, bus_write, bus_address, write_word,
                     config_value, frame_error, output ready);
endinterface

// ===== hdl/spi_to_bus_bridge_slave_unit.sv =====
// SPI-to-bus bridge slave: per-byte frame decoder with an APB config port.
// Path: an accepted input word goes through the input register, then the result
// register, which holds its result word until it is taken.
// Throughput: one word per cycle; the input register drains whenever the
// result register is empty or being taken, so ready stays high under no stall.
// Reset (i_rst_n low, synchronous): pipeline empty, frame idle, all state zero,
// address_step back to 4.
module spi_to_bus_bridge_slave_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sbb_in_if.sink                         i_in,
    sbb_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sbb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import sbb_pkg::*;

    // Pipeline registers
    logic      r_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    t_out_word r_out;
    t_out_word n_out;

    // Frame state
    t_phase               r_phase, n_phase;
    logic [1:0]           r_count, n_count;
    t_kind                r_kind,  n_kind;
    logic [ADDR_BITS-1:0] r_addr,  n_addr;
    logic [31:0]          r_wbuf,  n_wbuf;
    logic [23:0]          r_cfg,   n_cfg;
    logic [23:0]          r_stat,  n_stat;
    logic [7:0]           r_step;

    logic                 w_adv;
    logic [4:0]           w_sh;
    logic [31:0]          w_byte32;
    logic [31:0]          w_rsel;
    logic [ADDR_BITS-1:0] w_addr_inc;
    logic                 w_last;

    // Handshake: input register moves on when the result slot is free
    assign w_adv        = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready   = !r_in_vld || w_adv;

    // Byte lane helpers
    assign w_sh       = {r_count, 3'b000};
    assign w_byte32   = {24'd0, r_in.mosi_byte} << w_sh;
    assign w_last     = (r_count == 2'd3);
    assign w_rsel     = (r_count == 2'd0) ? r_in.read_word : r_wbuf;
    assign w_addr_inc = r_addr + {{(ADDR_BITS-8){1'b0}}, r_step};

    // Next-state logic
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_kind  = r_kind;
        n_addr  = r_addr;
        n_wbuf  = r_wbuf;
        n_cfg   = r_cfg;
        n_stat  = r_stat;
        if (r_in.frame_end) begin
            n_phase = PH_IDLE;
            n_count = 2'd0;
            n_kind  = KIND_NONE;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    n_count = 2'd0;
                    if (r_in.mosi_byte == CMD_READ || r_in.mosi_byte == CMD_WRITE) begin
                        n_kind  = (r_in.mosi_byte == CMD_READ) ? KIND_READ : KIND_WRITE;
                        n_phase = PH_ADDR;
                        n_addr  = '0;
                    end else if (r_in.mosi_byte == CMD_CFG_RD ||
                                 r_in.mosi_byte == CMD_STATUS) begin
                        n_stat  = (r_in.mosi_byte == CMD_STATUS) ? r_in.status_word : r_cfg;
                        n_kind  = KIND_NONE;
                        n_phase = PH_REPLY;
                    end else if (r_in.mosi_byte == CMD_CFG_WR) begin
                        n_kind  = KIND_NONE;
                        n_wbuf  = '0;
                        n_phase = PH_CFGWR;
                    end else begin
                        n_kind  = KIND_BAD;
                        n_phase = PH_DRAIN;
                    end
                end
                PH_ADDR: begin
                    n_addr = r_addr | w_byte32[ADDR_BITS-1:0];
                    if (r_count >= 2'd2) begin
                        n_count = 2'd0;
                        n_phase = (r_kind == KIND_READ) ? PH_DUMMY : PH_WDATA;
                        n_wbuf  = '0;
                    end else begin
                        n_count = r_count + 2'd1;
                    end
                end
                PH_DUMMY: begin
                    n_count = 2'd0;
                    n_phase = PH_RDATA;
                end
                PH_RDATA: begin
                    n_wbuf = w_rsel;
                    if (w_last) begin
                        n_addr  = w_addr_inc;
                        n_count = 2'd0;
                    end else begin
                        n_count = r_count + 2'd1;
                    end
                end
                PH_WDATA: begin
                    n_wbuf = ((r_count == 2'd0) ? 32'd0 : r_wbuf) | w_byte32;
                    if (w_last) begin
                        n_addr  = w_addr_inc;
                        n_count = 2'd0;
                    end else begin
                        n_count = r_count + 2'd1;
                    end
                end
                PH_REPLY: begin
                    if (r_count >= 2'd2) begin
                        n_count = 2'd0;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_count = r_count + 2'd1;
                    end
                end
                PH_CFGWR: begin
                    n_wbuf = r_wbuf | w_byte32;
                    if (r_count >= 2'd2) begin
                        n_cfg   = n_wbuf[23:0];
                        n_count = 2'd0;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_count = r_count + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result word logic
    always_comb begin
        n_out              = '0;
        n_out.bus_address  = 24'(32'(r_addr));
        n_out.config_value = n_cfg;
        if (!r_in.frame_end) begin
            case (r_phase)
                PH_IDLE: begin
                    n_out.bus_address = 24'(32'(n_addr));
                    n_out.frame_error = (n_kind == KIND_BAD);
                end
                PH_ADDR: begin
                    n_out.bus_address = 24'(32'(n_addr));
                end
                PH_DUMMY: begin
                    n_out.bus_read = 1'b1;
                end
                PH_RDATA: begin
                    n_out.miso_byte   = 8'(w_rsel >> w_sh);
                    n_out.bus_read    = w_last;
                    n_out.bus_address = 24'(32'(n_addr));
                end
                PH_WDATA: begin
                    n_out.bus_write  = w_last;
                    n_out.write_word = w_last ? n_wbuf : 32'd0;
                end
                PH_REPLY: begin
                    n_out.miso_byte = 8'(r_stat >> w_sh);
                end
                PH_CFGWR: begin
                end
                default: begin
                    n_out.frame_error = (r_kind == KIND_BAD);
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in.frame_end   <= i_in.frame_end;
            r_in.mosi_byte   <= i_in.mosi_byte;
            r_in.read_word   <= i_in.read_word;
            r_in.status_word <= i_in.status_word;
        end
    end

    // Frame state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= 2'd0;
            r_kind  <= KIND_NONE;
            r_addr  <= '0;
            r_wbuf  <= '0;
            r_cfg   <= '0;
            r_stat  <= '0;
        end else if (w_adv) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_kind  <= n_kind;
            r_addr  <= n_addr;
            r_wbuf  <= n_wbuf;
            r_cfg   <= n_cfg;
            r_stat  <= n_stat;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.miso_byte    = r_out.miso_byte;
    assign o_out.bus_read     = r_out.bus_read;
    assign o_out.bus_write    = r_out.bus_write;
    assign o_out.bus_address  = r_out.bus_address;
    assign o_out.write_word   = r_out.write_word;
    assign o_out.config_value = r_out.config_value;
    assign o_out.frame_error  = r_out.frame_error;

    // APB register: burst address step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_ADDR_STEP) begin
            r_step <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ADDR_STEP) ? {24'd0, r_step} : 32'd0;

endmodule

// ===== hdl/sbb_checker.sv =====
// Port-level checker for the bridge, bound to the top level.
`include "spi_to_bus_bridge_slave_unit_defines.svh"

module sbb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_bus_read,
    input logic                           i_bus_write,
    input logic [31:0]                    i_write_word,
    input logic                           i_psel,
    input logic                           i_penable,
    input logic                           i_pwrite,
    input logic [sbb_pkg::APB_ADDR_W-1:0] i_paddr,
    input logic [31:0]                    i_pwdata,
    input logic [31:0]                    i_prdata
);
    import sbb_pkg::*;

    // Reset empties the result register
    `SBB_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // A word never asks for both a bus read and a bus write
    `SBB_ASSERT(a_rd_wr_excl, i_clk, i_rst_n, i_out_valid |-> !(i_bus_read && i_bus_write), "read and write together")

    // Write data is zero unless a write is issued
    `SBB_ASSERT(a_wdata_zero, i_clk, i_rst_n, (i_out_valid && !i_bus_write) |-> (i_write_word == 32'd0), "write word without write")

    // A stalled result word holds
    `SBB_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_bus_read) && $stable(i_bus_write)), "stalled result changed")

    // Step register reads back what was written
    `SBB_ASSERT(a_step_rb, i_clk, i_rst_n, (i_psel && i_penable && i_pwrite && i_paddr == REG_ADDR_STEP) |=> (i_paddr != REG_ADDR_STEP || i_prdata == {24'd0, $past(i_pwdata[7:0])}), "step readback mismatch")

endmodule

bind spi_to_bus_bridge_slave_unit sbb_checker u_sbb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_bus_read   (o_out.bus_read),
    .i_bus_write  (o_out.bus_write),
    .i_write_word (o_out.write_word),
    .i_psel       (psel),
    .i_penable    (penable),
    .i_pwrite     (pwrite),
    .i_paddr      (paddr),
    .i_pwdata     (pwdata),
    .i_prdata     (prdata)
);
